// ===== hdl/encspd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encspd_pkg
// shared types and constants of the encoder speed estimator
// ----------------------------------------------------------------------------
package encspd_pkg;

    // field widths of the external channels
    localparam int CMD_BITS        = 2;
    localparam int FIELD_POS_BITS  = 17;
    localparam int FIELD_TICK_BITS = 32;
    localparam int SPEED_BITS      = 32;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 32;

    typedef logic [CMD_BITS-1:0]       t_command;
    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;

    // request commands
    localparam t_command CMD_TICK     = 2'd0;
    localparam t_command CMD_SAMPLE   = 2'd1;
    localparam t_command CMD_BASELINE = 2'd2;

    // configuration register indexes
    localparam t_cfg_index REG_COUNTS_PER_REV = 2'd0;
    localparam t_cfg_index REG_SPEED_SCALE    = 2'd1;

    localparam logic [FIELD_POS_BITS-1:0] CPR_RESET = 17'd116000;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;

endpackage

// ===== hdl/encspd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encspd_front
// request decode, tick counter, baseline state and delta forming
// ----------------------------------------------------------------------------
module encspd_front #(
    parameter int POSITION_BITS = 17,
    parameter int TICK_BITS     = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  encspd_pkg::t_command                   i_command,
    input  logic [encspd_pkg::FIELD_POS_BITS-1:0]  i_position,
    input  logic [encspd_pkg::FIELD_POS_BITS-1:0]  i_counts_per_rev,
    input  logic                                   i_full,
    output logic                                   o_push,
    output logic [POSITION_BITS-1:0]               o_position_delta,
    output logic [TICK_BITS-1:0]                   o_tick_delta
);

    localparam int PIN_BITS = (POSITION_BITS < encspd_pkg::FIELD_POS_BITS) ?
                              POSITION_BITS : encspd_pkg::FIELD_POS_BITS;

    logic [TICK_BITS-1:0]     r_tick_counter, n_tick_counter;
    logic [TICK_BITS-1:0]     r_last_tick, n_last_tick;
    logic [POSITION_BITS-1:0] r_last_position, n_last_position;

    logic                     w_fire;
    logic                     w_is_sample;
    logic [POSITION_BITS-1:0] w_pos;
    logic [POSITION_BITS-1:0] w_cpr;

    assign w_is_sample = (i_command == encspd_pkg::CMD_SAMPLE);
    // only a sample needs a queue slot
    assign o_ready     = !i_full || !w_is_sample;
    assign w_fire      = i_valid && o_ready;
    assign o_push      = w_fire && w_is_sample;

    assign w_pos = POSITION_BITS'(i_position[PIN_BITS-1:0]);
    assign w_cpr = POSITION_BITS'(i_counts_per_rev);

    // forward move or wrap past the revolution boundary
    assign o_position_delta = (w_pos >= r_last_position) ? (w_pos - r_last_position)
                                                         : (w_cpr - r_last_position + w_pos);
    assign o_tick_delta     = r_tick_counter - r_last_tick;

    always_comb begin
        n_tick_counter  = r_tick_counter;
        n_last_tick     = r_last_tick;
        n_last_position = r_last_position;
        if (w_fire) begin
            unique case (i_command) inside
                encspd_pkg::CMD_TICK: begin
                    n_tick_counter = r_tick_counter + TICK_BITS'(1);
                end
                encspd_pkg::CMD_SAMPLE, encspd_pkg::CMD_BASELINE: begin
                    n_last_tick     = r_tick_counter;
                    n_last_position = w_pos;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_counter  <= '0;
            r_last_tick     <= '0;
            r_last_position <= '0;
        end else begin
            r_tick_counter  <= n_tick_counter;
            r_last_tick     <= n_last_tick;
            r_last_position <= n_last_position;
        end
    end

endmodule

// ===== hdl/encspd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encspd_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module encspd_queue #(
    parameter int DATA_BITS = 49
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output logic [DATA_BITS-1:0] o_data
);

    localparam int DEPTH     = encspd_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [PTR_BITS-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0]  r_count;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_BITS'(1);
                2'b01:   r_count <= r_count - CNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/encspd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encspd_back
// scale multiply, overflow check, serial restoring divide, result register
// ----------------------------------------------------------------------------
module encspd_back #(
    parameter int POSITION_BITS = 17,
    parameter int TICK_BITS     = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [encspd_pkg::SPEED_BITS-1:0]      i_speed_scale,
    input  logic                                   i_job_valid,
    input  logic [POSITION_BITS-1:0]               i_position_delta,
    input  logic [TICK_BITS-1:0]                   i_tick_delta,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [encspd_pkg::SPEED_BITS-1:0]      o_speed,
    output logic [encspd_pkg::FIELD_POS_BITS-1:0]  o_position_delta,
    output logic [encspd_pkg::FIELD_TICK_BITS-1:0] o_tick_delta,
    output logic                                   o_zero_interval
);

    localparam int QB        = encspd_pkg::SPEED_BITS;
    localparam int PROD_BITS = QB + POSITION_BITS;
    localparam int CMP_BITS  = (POSITION_BITS > TICK_BITS) ? POSITION_BITS : TICK_BITS;
    localparam int CNT_BITS  = $clog2(QB);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]               r_state;
    logic [CNT_BITS-1:0]      r_count;
    logic [POSITION_BITS-1:0] r_pd;
    logic [TICK_BITS-1:0]     r_td;
    logic                     r_zero;
    logic [PROD_BITS-1:0]     r_product;
    logic [TICK_BITS-1:0]     r_rem;
    logic [QB-1:0]            r_low;
    logic [QB-1:0]            r_speed;

    logic [POSITION_BITS-1:0] w_prod_hi;
    logic                     w_overflow;
    logic [TICK_BITS:0]       w_shifted;
    logic [TICK_BITS:0]       w_diff;
    logic                     w_ge;
    logic [TICK_BITS-1:0]     n_rem;
    logic [QB-1:0]            n_low;

    assign o_pop = (r_state == S_IDLE) && i_job_valid;

    // quotient fits in QB bits only when the high part is below the divisor
    assign w_prod_hi  = r_product[PROD_BITS-1:QB];
    assign w_overflow = (CMP_BITS'(w_prod_hi) >= CMP_BITS'(r_td));

    // one restoring divide step
    assign w_shifted = {r_rem, r_low[QB-1]};
    assign w_diff    = w_shifted - {1'b0, r_td};
    assign w_ge      = (w_shifted >= {1'b0, r_td});
    assign n_rem     = w_ge ? w_diff[TICK_BITS-1:0] : w_shifted[TICK_BITS-1:0];
    assign n_low     = {r_low[QB-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pd   <= i_position_delta;
            r_td   <= i_tick_delta;
            r_zero <= (i_tick_delta == '0);
        end
        if (r_state == S_MUL) begin
            r_product <= PROD_BITS'(i_speed_scale) * PROD_BITS'(r_pd);
        end
        if (r_state == S_CHECK) begin
            r_rem <= TICK_BITS'(w_prod_hi);
            r_low <= r_product[QB-1:0];
            if (r_zero) begin
                r_speed <= '0;
            end else if (w_overflow) begin
                r_speed <= encspd_pkg::SPEED_MAX;
            end
        end
        if (r_state == S_DIV) begin
            r_rem <= n_rem;
            r_low <= n_low;
            if (r_count == CNT_BITS'(QB - 1)) begin
                r_speed <= n_low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_count <= '0;
                    r_state <= (r_zero || w_overflow) ? S_OUT : S_DIV;
                end
                S_DIV: begin
                    r_count <= r_count + CNT_BITS'(1);
                    if (r_count == CNT_BITS'(QB - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = (r_state == S_OUT);
    assign o_speed          = r_speed;
    assign o_position_delta = encspd_pkg::FIELD_POS_BITS'(r_pd);
    assign o_tick_delta     = encspd_pkg::FIELD_TICK_BITS'(r_td);
    assign o_zero_interval  = r_zero;

endmodule

// ===== hdl/encoder_speed_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_speed_estimator
// quadrature encoder speed measurement in unsigned q16.16 rev/s
// ----------------------------------------------------------------------------
//
// channel  | dir | handshake               | payload
// ---------+-----+-------------------------+-------------------------------------
// in       | in  | i_in_valid / o_in_ready | i_command, i_position
// out      | out | o_out_valid/i_out_ready | o_speed, o_position_delta,
//          |     |                         | o_tick_delta, o_zero_interval
// cfg      | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// - tick, baseline and unused requests are handled in the front and give no result
// - a sample passes through the back in order: pop, multiply, overflow check,
//   32 restoring divide steps (one quotient bit per cycle), result register;
//   the divide loop sets the sustained sample rate
// - a zero interval or a saturated quotient skips the divide
// - a two-entry queue parts front and back; the front keeps taking ticks and
//   baselines while the back waits on a stalled result
// - synchronous active-low reset clears counters, last position and control;
//   configuration returns to counts_per_rev 116000, speed_scale 0
//
module encoder_speed_estimator #(
    parameter int POSITION_BITS = 17,
    parameter int TICK_BITS     = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // request channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [encspd_pkg::CMD_BITS-1:0]        i_command,
    input  logic [encspd_pkg::FIELD_POS_BITS-1:0]  i_position,
    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [encspd_pkg::SPEED_BITS-1:0]      o_speed,
    output logic [encspd_pkg::FIELD_POS_BITS-1:0]  o_position_delta,
    output logic [encspd_pkg::FIELD_TICK_BITS-1:0] o_tick_delta,
    output logic                                   o_zero_interval,
    // configuration channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [encspd_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [encspd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int JOB_BITS = POSITION_BITS + TICK_BITS;

    // configuration registers
    logic [encspd_pkg::FIELD_POS_BITS-1:0] r_counts_per_rev;
    logic [encspd_pkg::SPEED_BITS-1:0]     r_speed_scale;

    // front to queue
    logic                     w_push;
    logic [POSITION_BITS-1:0] w_front_pd;
    logic [TICK_BITS-1:0]     w_front_td;
    logic                     w_q_full;

    // queue to back
    logic                     w_q_valid;
    logic                     w_pop;
    logic [JOB_BITS-1:0]      w_q_data;

    // writes always taken; user writes only when the block is idle; not enforced
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts_per_rev <= encspd_pkg::CPR_RESET;
            r_speed_scale    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                encspd_pkg::REG_COUNTS_PER_REV: begin
                    r_counts_per_rev <= i_cfg_data[encspd_pkg::FIELD_POS_BITS-1:0];
                end
                encspd_pkg::REG_SPEED_SCALE: begin
                    r_speed_scale <= i_cfg_data[encspd_pkg::SPEED_BITS-1:0];
                end
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // request decode and delta forming
    encspd_front #(
        .POSITION_BITS (POSITION_BITS),
        .TICK_BITS     (TICK_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_ready          (o_in_ready),
        .i_command        (i_command),
        .i_position       (i_position),
        .i_counts_per_rev (r_counts_per_rev),
        .i_full           (w_q_full),
        .o_push           (w_push),
        .o_position_delta (w_front_pd),
        .o_tick_delta     (w_front_td)
    );

    // sample jobs waiting for the divider
    encspd_queue #(
        .DATA_BITS (JOB_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_pd, w_front_td}),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // speed arithmetic and result register
    encspd_back #(
        .POSITION_BITS (POSITION_BITS),
        .TICK_BITS     (TICK_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_speed_scale    (r_speed_scale),
        .i_job_valid      (w_q_valid),
        .i_position_delta (w_q_data[JOB_BITS-1:TICK_BITS]),
        .i_tick_delta     (w_q_data[TICK_BITS-1:0]),
        .o_pop            (w_pop),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_speed          (o_speed),
        .o_position_delta (o_position_delta),
        .o_tick_delta     (o_tick_delta),
        .o_zero_interval  (o_zero_interval)
    );

    // zero flag tracks the tick delta of the same result
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_zero_interval == (o_tick_delta == '0)))
        else $error("zero_interval does not match tick_delta");

    // zero interval forces zero speed
    a_zero_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_interval) |-> (o_speed == '0))
        else $error("nonzero speed on zero interval");

    // zero scale gives zero speed through the divide path
    a_zero_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_speed_scale == '0)) |-> (o_speed == '0))
        else $error("nonzero speed with zero scale");

    // the back only pops a job that is present
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_q_valid && !o_out_valid))
        else $error("job popped from empty queue or while result pending");

endmodule

// ===== dv/tb_encoder_speed_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_speed_estimator
// self-checking bench: directed corner requests, then random measurement
// sequences under several register settings, with random stalls on both
// channels; each result is compared field by field against a bit-true predictor
// ----------------------------------------------------------------------------
module tb_encoder_speed_estimator;

    typedef logic [encspd_pkg::FIELD_POS_BITS-1:0]  t_pos;
    typedef logic [encspd_pkg::FIELD_TICK_BITS-1:0] t_tick;
    typedef logic [encspd_pkg::SPEED_BITS-1:0]      t_speed;

    typedef struct packed {
        t_speed speed;
        t_pos   pos_delta;
        t_tick  tick_delta;
        logic   zero_interval;
    } t_speed_result;

    // codes the block ignores
    localparam encspd_pkg::t_command   CMD_UNUSED = 2'd3;
    localparam encspd_pkg::t_cfg_index REG_UNUSED = 2'd3;

    // margin after the longest back-end job
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 400000;

    // ------------------------------------------------------------------------
    // speed predictor and store of expected measurements
    // ------------------------------------------------------------------------
    class speed_predictor;
        t_pos          counts_per_rev;
        t_speed        speed_scale;
        t_tick         tick_count;
        t_tick         last_tick;
        t_pos          last_pos;
        t_speed_result expected_q[$];
        int            errors;

        function new();
            counts_per_rev = encspd_pkg::CPR_RESET;
            speed_scale    = '0;
            tick_count     = '0;
            last_tick      = '0;
            last_pos       = '0;
            errors         = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_reg(encspd_pkg::t_cfg_index idx,
                              logic [encspd_pkg::CFG_DATA_BITS-1:0] data);
            case (idx)
                encspd_pkg::REG_COUNTS_PER_REV:
                    counts_per_rev = data[encspd_pkg::FIELD_POS_BITS-1:0];
                encspd_pkg::REG_SPEED_SCALE:
                    speed_scale    = data;
                default: ;
            endcase
        endfunction

        // update state for one accepted request, queue a result for a sample
        function void note_request(encspd_pkg::t_command cmd, t_pos pos);
            t_speed_result want;
            logic [63:0]   product;
            logic [63:0]   quotient;
            case (cmd)
                encspd_pkg::CMD_TICK: tick_count = tick_count + 1'b1;
                encspd_pkg::CMD_BASELINE: begin
                    last_pos  = pos;
                    last_tick = tick_count;
                end
                encspd_pkg::CMD_SAMPLE: begin
                    // backward motion wraps at counts_per_rev, sum kept at field width
                    if (pos >= last_pos)
                        want.pos_delta = pos - last_pos;
                    else
                        want.pos_delta = counts_per_rev - last_pos + pos;
                    want.tick_delta    = tick_count - last_tick;
                    want.zero_interval = (want.tick_delta == '0);
                    if (want.zero_interval) begin
                        want.speed = '0;
                    end else begin
                        product    = 64'(speed_scale) * 64'(want.pos_delta);
                        quotient   = product / 64'(want.tick_delta);
                        want.speed = (quotient > 64'(encspd_pkg::SPEED_MAX)) ?
                                     encspd_pkg::SPEED_MAX :
                                     quotient[encspd_pkg::SPEED_BITS-1:0];
                    end
                    last_pos  = pos;
                    last_tick = tick_count;
                    expected_q.push_back(want);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_speed_result got);
            t_speed_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result speed %h pos_delta %h tick_delta %h zero %b",
                         $time, got.speed, got.pos_delta, got.tick_delta, got.zero_interval);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.speed !== want.speed) begin
                $display("%0t: speed expected %h got %h", $time, want.speed, got.speed);
                errors++;
            end
            if (got.pos_delta !== want.pos_delta) begin
                $display("%0t: position_delta expected %h got %h",
                         $time, want.pos_delta, got.pos_delta);
                errors++;
            end
            if (got.tick_delta !== want.tick_delta) begin
                $display("%0t: tick_delta expected %h got %h",
                         $time, want.tick_delta, got.tick_delta);
                errors++;
            end
            if (got.zero_interval !== want.zero_interval) begin
                $display("%0t: zero_interval expected %b got %b",
                         $time, want.zero_interval, got.zero_interval);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_in_valid  = 1'b0;
    logic                                 o_in_ready;
    encspd_pkg::t_command                 i_command   = encspd_pkg::CMD_TICK;
    t_pos                                 i_position  = '0;
    logic                                 o_out_valid;
    logic                                 i_out_ready = 1'b0;
    t_speed                               o_speed;
    t_pos                                 o_position_delta;
    t_tick                                o_tick_delta;
    logic                                 o_zero_interval;
    logic                                 i_cfg_valid = 1'b0;
    logic                                 o_cfg_ready;
    encspd_pkg::t_cfg_index               i_cfg_index = encspd_pkg::REG_COUNTS_PER_REV;
    logic [encspd_pkg::CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    speed_predictor sb = new();
    bit             quiet;          // no gaps or stalls on either side
    int             cycle_count;
    int             stall_left;
    int             ready_roll;

    encoder_speed_estimator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_position       (i_position),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_speed          (o_speed),
        .o_position_delta (o_position_delta),
        .o_tick_delta     (o_tick_delta),
        .o_zero_interval  (o_zero_interval),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_encoder_speed_estimator failed");
            $finish;
        end
    end

    // result side back-pressure: mostly ready, short and occasional long stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else if (quiet) begin
            i_out_ready <= 1'b1;
        end else if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 80) begin
                i_out_ready <= 1'b1;
            end else if (ready_roll < 95) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(10, 60);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(t_speed_result'({o_speed, o_position_delta,
                                              o_tick_delta, o_zero_interval}));
    end

    // ------------------------------------------------------------------------
    // request driving
    // ------------------------------------------------------------------------
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // valid stays high after a request is taken unless a gap follows
    task automatic send_request(encspd_pkg::t_command cmd, t_pos pos);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_position <= pos;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(cmd, pos);
    endtask

    // hold off until every result is back, then let the front end go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(encspd_pkg::t_cfg_index idx,
                             logic [encspd_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // registers only change with the block idle; upper data bits of the
    // count register are junk on purpose
    task automatic set_config(t_pos cpr, t_speed scale, bit poke_unused);
        settle();
        if (poke_unused)
            cfg_write(REG_UNUSED, $urandom());
        cfg_write(encspd_pkg::REG_COUNTS_PER_REV, {15'($urandom()), cpr});
        cfg_write(encspd_pkg::REG_SPEED_SCALE, scale);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly in range, with the edges and out-of-range values mixed in
    function automatic t_pos pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70 && sb.counts_per_rev != 0)
            return t_pos'($urandom_range(0, sb.counts_per_rev - 1));
        else if (r < 78)
            return '0;
        else if (r < 86)
            return '1;
        else if (r < 90 && sb.counts_per_rev != 0)
            return sb.counts_per_rev - 1'b1;
        else
            return t_pos'($urandom());
    endfunction

    function automatic int tick_run();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 4);
        else if (r < 95)
            return $urandom_range(5, 30);
        else
            return $urandom_range(50, 200);
    endfunction

    // measurement sequences (optional baseline, ticks, sample) plus some noise
    task automatic run_measurements(int n_items);
        int                   sent;
        int                   r;
        int                   k;
        encspd_pkg::t_command cmd;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 3 && sb.pending() != 0) begin
                // sender holds off until the back end has drained
                i_in_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end else if (r < 88) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_request(encspd_pkg::CMD_BASELINE, pick_position());
                    sent++;
                end
                k = tick_run();
                repeat (k) send_request(encspd_pkg::CMD_TICK, t_pos'($urandom()));
                sent += k;
                send_request(encspd_pkg::CMD_SAMPLE, pick_position());
                sent++;
            end else begin
                cmd = encspd_pkg::t_command'($urandom_range(0, 3));
                send_request(cmd, t_pos'($urandom()));
                if (cmd != CMD_UNUSED)
                    sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        quiet = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers, zero scale: sample with no elapsed ticks, then
        // the largest position
        send_request(encspd_pkg::CMD_SAMPLE, '0);
        send_request(encspd_pkg::CMD_TICK, '1);
        send_request(encspd_pkg::CMD_SAMPLE, '1);

        // full scale: saturation, backward wrap, ignored command, wrap of an
        // out-of-range position
        set_config(17'd116000, '1, 1'b1);
        send_request(encspd_pkg::CMD_BASELINE, 17'd1000);
        send_request(encspd_pkg::CMD_TICK, '0);
        send_request(encspd_pkg::CMD_SAMPLE, 17'd115999);
        send_request(encspd_pkg::CMD_SAMPLE, 17'd10);
        send_request(CMD_UNUSED, '1);
        send_request(encspd_pkg::CMD_TICK, '0);
        send_request(encspd_pkg::CMD_TICK, '0);
        send_request(encspd_pkg::CMD_SAMPLE, '1);
        send_request(encspd_pkg::CMD_TICK, '0);
        send_request(encspd_pkg::CMD_SAMPLE, '0);

        // one count per revolution, unit scale
        set_config(17'd1, 32'h0001_0000, 1'b0);
        send_request(encspd_pkg::CMD_BASELINE, '0);
        repeat (3) send_request(encspd_pkg::CMD_TICK, '1);
        send_request(encspd_pkg::CMD_SAMPLE, '0);
        send_request(encspd_pkg::CMD_TICK, '0);
        send_request(encspd_pkg::CMD_SAMPLE, 17'd5);
        send_request(encspd_pkg::CMD_TICK, '0);
        send_request(encspd_pkg::CMD_SAMPLE, 17'd2);

        // zero counts per revolution, no special handling in the wrap
        set_config('0, 32'd3, 1'b0);
        send_request(encspd_pkg::CMD_TICK, '0);
        send_request(encspd_pkg::CMD_SAMPLE, 17'd1);
        send_request(encspd_pkg::CMD_SAMPLE, '1);

        // random phases over a spread of settings
        set_config('1, '0, 1'b0);
        run_measurements(80);
        set_config('1, '1, 1'b0);
        run_measurements(80);
        set_config(t_pos'($urandom_range(1, 131071)), $urandom(), 1'b1);
        run_measurements(80);
        set_config(17'd116000, $urandom_range(0, 32'h0010_0000), 1'b0);
        quiet = 1'b1;
        run_measurements(80);
        quiet = 1'b0;
        set_config(17'd1, $urandom(), 1'b0);
        run_measurements(80);
        set_config(t_pos'($urandom_range(1, 131071)), $urandom_range(0, 32'h0100_0000), 1'b0);
        run_measurements(80);

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_encoder_speed_estimator passed");
        else
            $display("tb_encoder_speed_estimator failed");
        $finish;
    end

endmodule
